>>> rtl/rbh_pkg.sv
// Shared types and constants for the range bucket histogram.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rbh_pkg;

  localparam int MAX_BOUNDS     = 7;
  localparam int COUNT_WIDTH    = 32;
  localparam int NUM_BOUND_REGS = 7;
  localparam int NUM_BUCKETS    = MAX_BOUNDS + 1;
  localparam int CNT_IDX_W      = (NUM_BUCKETS > 2) ? $clog2(NUM_BUCKETS) : 1;

  localparam int SAMPLE_W    = 16;
  localparam int BOUND_CNT_W = 3;
  localparam int BUCKET_W    = 3;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DATA_W  = ((BUCKET_W + COUNT_WIDTH + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_BOUND_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_BASE  = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_COUNT      = 2'd0,
    OP_COUNT_EMIT = 2'd1,
    OP_EMIT       = 2'd2,
    OP_NOP        = 2'd3
  } op_e;

  typedef logic [CNT_IDX_W-1:0]   cnt_idx_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  // Command from the input stage to the counter bank.
  typedef struct packed {
    logic     inc;
    cnt_idx_t idx;
    logic     clear;
  } cnt_cmd_t;

endpackage

`default_nettype wire

>>> rtl/rbh_classify.sv
// Bucket selection: parallel compares of one sample against the boundaries.
// Depends on rbh_pkg.
`default_nettype none

module rbh_classify
  import rbh_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [SAMPLE_W-1:0] bounds_i [NUM_BOUND_REGS],
  input  wire cnt_idx_t            active_i,
  output cnt_idx_t                 bucket_o
);

  // Scanning downward makes the lowest matching boundary win.
  always_comb begin
    bucket_o = active_i;
    for (int b = MAX_BOUNDS - 1; b >= 0; b--) begin
      if ((CNT_IDX_W'(b) < active_i) && (sample_i < bounds_i[b])) begin
        bucket_o = CNT_IDX_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbh_counters.sv
// Bank of saturating bucket counters with a clear on emit.
// Depends on rbh_pkg.
`default_nettype none

module rbh_counters
  import rbh_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cnt_cmd_t cmd_i,
  output count_t    snap_o [NUM_BUCKETS]
);

  count_t counts_q [NUM_BUCKETS];
  count_t counts_d [NUM_BUCKETS];

  // The snapshot already includes the increment of the item being committed.
  always_comb begin
    for (int k = 0; k < NUM_BUCKETS; k++) begin
      snap_o[k] = counts_q[k];
      if (cmd_i.inc && (cmd_i.idx == CNT_IDX_W'(k)) && !(&counts_q[k])) begin
        snap_o[k] = counts_q[k] + COUNT_WIDTH'(1);
      end
      counts_d[k] = cmd_i.clear ? '0 : snap_o[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        counts_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        counts_q[k] <= counts_d[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rbh_emit.sv
// Emit buffer and output register: holds a snapshot of the counters and
// sends one bucket word per cycle unless the output stalls. Depends on rbh_pkg.
`default_nettype none

module rbh_emit
  import rbh_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire cnt_idx_t              active_i,
  input  wire count_t                snap_i [NUM_BUCKETS],
  output logic                       busy_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // bucket_index [2:0], bucket_total above it, zero padded
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast
);

  count_t   buf_q [NUM_BUCKETS];
  cnt_idx_t idx_q, idx_d;
  cnt_idx_t last_q;
  logic     busy_q, busy_d;
  logic     out_valid_q, out_valid_d;
  cnt_idx_t out_idx_q;
  count_t   out_total_q;
  logic     out_last_q;
  logic     drain;
  logic     drain_last;

  assign drain      = busy_q && (!out_valid_q || m_axis_tready);
  assign drain_last = idx_q == last_q;

  always_comb begin
    idx_d       = idx_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (drain) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + CNT_IDX_W'(1);
      if (drain_last) begin
        busy_d = 1'b0;
      end
    end
    if (load_i) begin
      idx_d  = '0;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      last_q <= active_i;
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        buf_q[k] <= snap_i[k];
      end
    end
    if (drain) begin
      out_idx_q   <= idx_q;
      out_total_q <= buf_q[idx_q];
      out_last_q  <= drain_last;
    end
  end

  assign busy_o        = busy_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_total_q, BUCKET_W'(out_idx_q)});
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_q)
    else $error("emit snapshot loaded while a previous run is still draining");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain && drain_last |=> !busy_q)
    else $error("emit run did not end after its last bucket");

  a_idx_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !drain && !load_i |=> $stable(idx_q))
    else $error("bucket pointer moved while the output was stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/range_bucket_histogram.sv
// Range bucket histogram: 16-bit samples counted into up to eight ranges.
// One count item is taken per cycle unless an emit item is stalled ahead of it;
// an emit sends bound_count+1 words at one per cycle unless the output stalls,
// and a further emit item waits until the previous run has drained.
// Reset (rst_ni, asynchronous, active low) clears the counters, the registers
// and all valid state; no clearing pass is needed.
`default_nettype none

module range_bucket_histogram
  import rbh_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // sample [15:0]
  input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,
  // op [1:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // bucket_index [2:0], bucket_total [34:3], zero padded
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  output logic                        m_axis_tlast
);

  logic [BOUND_CNT_W-1:0] bound_count_q;
  logic [SAMPLE_W-1:0]    bound_q [NUM_BOUND_REGS];
  logic [CFG_IDX_W-1:0]   bound_sel;
  logic [BOUND_CNT_W-1:0] active_full;
  cnt_idx_t               active;

  logic                   s1_valid_q;
  op_e                    s1_op_q;
  logic [SAMPLE_W-1:0]    s1_sample_q;
  logic                   s1_is_emit, s1_is_count, s1_commit;
  logic                   emit_busy;
  cnt_idx_t               bucket;
  cnt_cmd_t               cmd;
  count_t                 snap [NUM_BUCKETS];

  // Configuration registers.
  assign bound_sel = cfg_index_i - REG_BOUND_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_count_q <= '0;
      for (int k = 0; k < NUM_BOUND_REGS; k++) begin
        bound_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_BOUND_COUNT) begin
        bound_count_q <= cfg_wdata_i[BOUND_CNT_W-1:0];
      end else begin
        bound_q[bound_sel] <= cfg_wdata_i[SAMPLE_W-1:0];
      end
    end
  end

  assign active_full = (bound_count_q > BOUND_CNT_W'(MAX_BOUNDS)) ?
                       BOUND_CNT_W'(MAX_BOUNDS) : bound_count_q;
  assign active      = active_full[CNT_IDX_W-1:0];

  // Input stage.
  assign s1_is_emit  = (s1_op_q == OP_COUNT_EMIT) || (s1_op_q == OP_EMIT);
  assign s1_is_count = (s1_op_q == OP_COUNT) || (s1_op_q == OP_COUNT_EMIT);
  assign s1_commit   = s1_valid_q && (!s1_is_emit || !emit_busy);
  assign s_axis_tready = !s1_valid_q || s1_commit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op_q     <= op_e'(s_axis_tuser);
      s1_sample_q <= s_axis_tdata;
    end
  end

  rbh_classify u_classify (
    .sample_i (s1_sample_q),
    .bounds_i (bound_q),
    .active_i (active),
    .bucket_o (bucket)
  );

  assign cmd.inc   = s1_commit && s1_is_count;
  assign cmd.idx   = bucket;
  assign cmd.clear = s1_commit && s1_is_emit;

  rbh_counters u_counters (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .snap_o (snap)
  );

  rbh_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (cmd.clear),
    .active_i      (active),
    .snap_i        (snap),
    .busy_o        (emit_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> tb/tb_range_bucket_histogram.sv
// Self-checking testbench for range_bucket_histogram: directed and random sample streams,
// with an in-order bucket predictor checked word by word. Depends on rbh_pkg and the block.
`timescale 1ns / 100ps

module tb_range_bucket_histogram;
  import rbh_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
  } hist_item_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] index;
    count_t              total;
    logic                last;
  } bucket_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  range_bucket_histogram u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the register file and the counter bank.
  logic [BOUND_CNT_W-1:0] bound_count_sh = '0;
  logic [SAMPLE_W-1:0]    bound_sh [NUM_BOUND_REGS];
  count_t                 tally [NUM_BUCKETS];

  hist_item_t     send_queue [$];
  bucket_report_t expected_buckets [$];
  hist_item_t     next_word;
  bucket_report_t got_word;
  bucket_report_t want_word;

  logic word_taken = 1'b0;
  logic calm = 1'b0;
  logic hold_sender = 1'b0;
  int   mismatches = 0;
  int   cycles = 0;

  initial begin
    for (int i = 0; i < NUM_BOUND_REGS; i++) bound_sh[i] = '0;
    for (int i = 0; i < NUM_BUCKETS; i++) tally[i] = '0;
  end

  function automatic int live_bounds();
    int n;
    n = bound_count_sh;
    if (n > MAX_BOUNDS) n = MAX_BOUNDS;
    return n;
  endfunction

  // Classifies a sample or emits the bank, as the block does for one accepted word.
  task automatic tally_word(input hist_item_t item);
    int n;
    int slot;
    bucket_report_t rep;
    n = live_bounds();
    if (item.op == OP_COUNT || item.op == OP_COUNT_EMIT) begin
      slot = n;
      for (int b = n - 1; b >= 0; b--) begin
        if (item.sample < bound_sh[b]) slot = b;
      end
      if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
    end
    if (item.op == OP_COUNT_EMIT || item.op == OP_EMIT) begin
      for (int k = 0; k <= n; k++) begin
        rep.index = BUCKET_W'(k);
        rep.total = tally[k];
        rep.last  = (k == n);
        expected_buckets.push_back(rep);
      end
      for (int k = 0; k < NUM_BUCKETS; k++) tally[k] = '0;
    end
  endtask

  // Acceptance and checking share one block so the order within an edge is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.index = m_axis_tdata[BUCKET_W-1:0];
        got_word.total = m_axis_tdata[BUCKET_W +: COUNT_WIDTH];
        got_word.last  = m_axis_tlast;
        if (expected_buckets.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: index %0d total %0d last %0b",
                     got_word.index, got_word.total, got_word.last);
        end else begin
          want_word = expected_buckets.pop_front();
          if (got_word != want_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected index %0d total %0d last %0b, got %0d %0d %0b",
                       want_word.index, want_word.total, want_word.last,
                       got_word.index, got_word.total, got_word.last);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        tally_word(hist_item_t'({s_axis_tuser, s_axis_tdata}));
    end
  end

  // Sender and receiver, both changing at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || word_taken) begin
        if (send_queue.size() != 0 && !hold_sender && (calm || $urandom_range(0, 99) >= 8)) begin
          next_word = send_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_word.sample;
          s_axis_tuser  <= next_word.op;
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= SAMPLE_W'($urandom);
          s_axis_tuser  <= OP_W'($urandom);
        end
      end
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BOUND_COUNT) bound_count_sh = val[BOUND_CNT_W-1:0];
    else bound_sh[idx - REG_BOUND_BASE] = val[SAMPLE_W-1:0];
  endtask

  task automatic push_item(input op_e op, input logic [SAMPLE_W-1:0] sample);
    hist_item_t item;
    item.op = op;
    item.sample = sample;
    send_queue.push_back(item);
  endtask

  // Waits until the block is idle; count-only words leave nothing to wait on,
  // so the task also waits out the pipeline afterwards.
  task automatic drain();
    while (send_queue.size() != 0 || s_axis_tvalid || expected_buckets.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Holds the sender back until every outstanding result word has arrived.
  task automatic pause_sender();
    hold_sender = 1'b1;
    while (s_axis_tvalid || expected_buckets.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    hold_sender = 1'b0;
  endtask

  task automatic setup_ranges(input bit shuffled);
    logic [SAMPLE_W-1:0] vals [NUM_BOUND_REGS];
    logic [SAMPLE_W-1:0] tmp;
    int n;
    for (int i = 0; i < NUM_BOUND_REGS; i++) begin
      case ($urandom_range(0, 9))
        0:       vals[i] = '0;
        1:       vals[i] = '1;
        default: vals[i] = SAMPLE_W'($urandom);
      endcase
    end
    if (!shuffled) begin
      for (int i = 0; i < NUM_BOUND_REGS; i++)
        for (int j = 0; j < NUM_BOUND_REGS - 1 - i; j++)
          if (vals[j] > vals[j+1]) begin
            tmp = vals[j];
            vals[j] = vals[j+1];
            vals[j+1] = tmp;
          end
    end
    case ($urandom_range(0, 5))
      0:       n = 0;
      1:       n = MAX_BOUNDS;
      default: n = $urandom_range(0, 7);
    endcase
    // Upper bits of the count register are junk now and then; only the low bits count.
    if ($urandom_range(0, 3) == 0)
      write_reg(REG_BOUND_COUNT, {13'($urandom), BOUND_CNT_W'(n)});
    else
      write_reg(REG_BOUND_COUNT, CFG_DATA_W'(n));
    for (int i = 0; i < NUM_BOUND_REGS; i++)
      write_reg(REG_BOUND_BASE + CFG_IDX_W'(i), vals[i]);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int n;
    n = live_bounds();
    if (n > 0 && $urandom_range(0, 1) == 1)
      return bound_sh[$urandom_range(0, n - 1)] + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
    return SAMPLE_W'($urandom);
  endfunction

  function automatic op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return OP_COUNT;
    if (r < 88) return OP_COUNT_EMIT;
    if (r < 95) return OP_EMIT;
    return OP_NOP;
  endfunction

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a single bucket takes everything.
    push_item(OP_COUNT, 16'h0000);
    push_item(OP_COUNT, 16'hFFFF);
    push_item(OP_NOP, 16'hFFFF);
    push_item(OP_EMIT, 16'hA5A5);
    push_item(OP_COUNT_EMIT, 16'h1234);
    drain();

    // Full set of bounds with edge values and a repeated top bound.
    write_reg(REG_BOUND_COUNT, CFG_DATA_W'(MAX_BOUNDS));
    write_reg(REG_BOUND_BASE + 3'd0, 16'h0001);
    write_reg(REG_BOUND_BASE + 3'd1, 16'h0100);
    write_reg(REG_BOUND_BASE + 3'd2, 16'h7FFF);
    write_reg(REG_BOUND_BASE + 3'd3, 16'h8000);
    write_reg(REG_BOUND_BASE + 3'd4, 16'hFFFE);
    write_reg(REG_BOUND_BASE + 3'd5, 16'hFFFF);
    write_reg(REG_BOUND_BASE + 3'd6, 16'hFFFF);
    push_item(OP_COUNT, 16'h0000);
    push_item(OP_COUNT, 16'h0001);
    push_item(OP_COUNT, 16'h00FF);
    push_item(OP_COUNT, 16'h0100);
    push_item(OP_COUNT, 16'h7FFF);
    push_item(OP_COUNT, 16'h8000);
    push_item(OP_COUNT, 16'hFFFE);
    push_item(OP_COUNT, 16'hFFFF);
    push_item(OP_NOP, 16'h0000);
    push_item(OP_COUNT_EMIT, 16'h5555);
    push_item(OP_EMIT, 16'h0000);
    push_item(OP_EMIT, 16'hFFFF);
    drain();

    // Unsorted bounds, then the count shrinks before the counters are emitted.
    write_reg(REG_BOUND_COUNT, 16'hFFF3);
    write_reg(REG_BOUND_BASE + 3'd0, 16'h9000);
    write_reg(REG_BOUND_BASE + 3'd1, 16'h1000);
    write_reg(REG_BOUND_BASE + 3'd2, 16'h5000);
    push_item(OP_COUNT, 16'h0800);
    push_item(OP_COUNT, 16'h9000);
    push_item(OP_COUNT, 16'h8FFF);
    push_item(OP_COUNT, 16'h4FFF);
    drain();
    write_reg(REG_BOUND_COUNT, 16'h0001);
    push_item(OP_EMIT, 16'h0000);
    push_item(OP_EMIT, 16'h0000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setup_ranges(p == 2 || p == 4);
      calm = (p == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Halfway through one phase the first half goes out, then the sender
        // holds off until every result has come back.
        if (p == 1 && i == ITEMS_PER_PHASE / 2) begin
          while (send_queue.size() != 0)
            @(posedge clk_i);
          pause_sender();
        end
        push_item(pick_op(), pick_sample());
      end
      push_item(OP_EMIT, SAMPLE_W'($urandom));
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && expected_buckets.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rbh_pkg.sv
rtl/rbh_classify.sv
rtl/rbh_counters.sv
rtl/rbh_emit.sv
rtl/range_bucket_histogram.sv
tb/tb_range_bucket_histogram.sv
